// ----- rtl/core/trd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and widths for the face tangent block.
// No dependencies; every other file in rtl/core imports this package.
package trd_pkg;

    localparam int POS_W  = 24;  // Q8.16 position
    localparam int TEX_W  = 18;  // Q2.16 texture coordinate
    localparam int EDGE_W = 25;  // Q9.16 edge
    localparam int UV_W   = 19;  // Q3.16 UV delta
    localparam int PROD_W = 44;  // UV_W x EDGE_W product
    localparam int NUM_W  = 45;  // difference of two products
    localparam int DET_W  = 39;  // Q7.32 determinant
    localparam int DIVD_W = 62;  // |num| << 16 plus rounding half
    localparam int REM_W  = 40;  // partial remainder of the divider
    localparam int OUT_W  = 32;  // Q16.16 result component
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 192;

    // One triangle's worth of work handed from the front end to the solver.
    typedef struct packed {
        logic signed [EDGE_W-1:0] ea_x;
        logic signed [EDGE_W-1:0] ea_y;
        logic signed [EDGE_W-1:0] ea_z;
        logic signed [EDGE_W-1:0] eb_x;
        logic signed [EDGE_W-1:0] eb_y;
        logic signed [EDGE_W-1:0] eb_z;
        logic signed [UV_W-1:0]   du1;
        logic signed [UV_W-1:0]   dv1;
        logic signed [UV_W-1:0]   du2;
        logic signed [UV_W-1:0]   dv2;
    } trd_job_t;

endpackage

// ----- rtl/core/trd_front.sv -----
`timescale 1ns / 1ps
// Vertex front end: holds the first two corners of a triangle and forms the
// edge and UV deltas on the third. Depends on trd_pkg.
module trd_front
    import trd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
    output logic                 job_valid,
    input  logic                 job_ready,
    output trd_job_t             job
);

    logic [1:0] corner_reg;
    logic [1:0] corner_next;

    logic signed [POS_W-1:0] px, py, pz;
    logic signed [TEX_W-1:0] tu, tv;

    logic signed [POS_W-1:0] h0x_reg, h0y_reg, h0z_reg, h1x_reg, h1y_reg, h1z_reg;
    logic signed [TEX_W-1:0] h0u_reg, h0v_reg, h1u_reg, h1v_reg;

    logic accept;
    logic third;

    assign px = s_tdata[23:0];
    assign py = s_tdata[47:24];
    assign pz = s_tdata[71:48];
    assign tu = s_tdata[89:72];
    assign tv = s_tdata[107:90];

    assign third     = (corner_reg == 2'd2);
    assign s_tready  = !third || job_ready;
    assign accept    = s_tvalid && s_tready;
    assign job_valid = s_tvalid && third;

    always_comb
    begin
        corner_next = corner_reg;
        if (accept)
        begin
            corner_next = third ? 2'd0 : corner_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= 2'd0;
        end
        else
        begin
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && corner_reg == 2'd0)
        begin
            h0x_reg <= px;
            h0y_reg <= py;
            h0z_reg <= pz;
            h0u_reg <= tu;
            h0v_reg <= tv;
        end
        if (accept && corner_reg == 2'd1)
        begin
            h1x_reg <= px;
            h1y_reg <= py;
            h1z_reg <= pz;
            h1u_reg <= tu;
            h1v_reg <= tv;
        end
    end

    // Deltas are exact: one extra bit on each difference.
    always_comb
    begin
        job.ea_x = EDGE_W'(h1x_reg) - EDGE_W'(h0x_reg);
        job.ea_y = EDGE_W'(h1y_reg) - EDGE_W'(h0y_reg);
        job.ea_z = EDGE_W'(h1z_reg) - EDGE_W'(h0z_reg);
        job.eb_x = EDGE_W'(px) - EDGE_W'(h0x_reg);
        job.eb_y = EDGE_W'(py) - EDGE_W'(h0y_reg);
        job.eb_z = EDGE_W'(pz) - EDGE_W'(h0z_reg);
        job.du1  = UV_W'(h1u_reg) - UV_W'(h0u_reg);
        job.dv1  = UV_W'(h1v_reg) - UV_W'(h0v_reg);
        job.du2  = UV_W'(tu) - UV_W'(h0u_reg);
        job.dv2  = UV_W'(tv) - UV_W'(h0v_reg);
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> corner_reg == 2'd2)
        else $error("job offered off the third corner");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && corner_reg == 2'd2) |=> corner_reg == 2'd0)
        else $error("corner counter did not wrap after a triangle");

    assert property (@(posedge clk) disable iff (!rst_n)
        corner_reg != 2'd3)
        else $error("corner counter out of range");

endmodule

// ----- rtl/core/trd_fifo.sv -----
`timescale 1ns / 1ps
// Small job queue between the vertex front end and the solver.
// Depends on trd_pkg for the job type.
module trd_fifo
    import trd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  trd_job_t wr_job,
    output logic     rd_valid,
    input  logic     rd_ready,
    output trd_job_t rd_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    trd_job_t         mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree when empty");

endmodule

// ----- rtl/core/trd_back.sv -----
`timescale 1ns / 1ps
// Solver: one shared multiplier forms the determinant and six numerators,
// a radix-2 divider forms each rounded quotient. Depends on trd_pkg.
module trd_back
    import trd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  trd_job_t              job,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // tangent x,y,z, bitangent x,y,z
    output logic [1:0]            m_tuser   // degenerate, clipped
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    trd_job_t job_reg;
    logic [3:0] step_reg;      // 0..14: product issue / retire counter
    logic [2:0] comp_reg;      // component 0..5
    logic [5:0] cnt_reg;       // divider bit counter
    logic       done_reg;      // result waiting for the output register

    logic signed [PROD_W-1:0] prod_reg, hold_reg;
    logic signed [NUM_W-1:0]  num_reg [7];   // entry 0 is the determinant
    logic [DIVD_W-1:0]        div_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DET_W-1:0]         ad_reg;
    logic                     neg_reg;
    logic [OUT_W-1:0]         res_reg [6];
    logic                     clip_reg, degen_reg;

    logic [OUT_DATA_W-1:0]    out_data_reg;
    logic [1:0]               out_user_reg;
    logic                     out_valid_reg;

    logic signed [EDGE_W-1:0] ea [3];
    logic signed [EDGE_W-1:0] eb [3];
    logic signed [UV_W-1:0]   mul_a;
    logic signed [EDGE_W-1:0] mul_b;
    logic [2:0]               pair;
    logic                     second;
    logic [1:0]               kidx;
    logic [3:0]               rstep;
    logic signed [DET_W-1:0]  det;
    logic                     det_zero;
    logic                     out_free;
    logic                     last_step;

    logic signed [NUM_W-1:0]  cur_num;
    logic [NUM_W-1:0]         an;
    logic [REM_W-1:0]         shifted;
    logic                     ge;
    logic [OUT_W-1:0]         sat_val;
    logic                     sat_clip;

    assign ea[0] = job_reg.ea_x;
    assign ea[1] = job_reg.ea_y;
    assign ea[2] = job_reg.ea_z;
    assign eb[0] = job_reg.eb_x;
    assign eb[1] = job_reg.eb_y;
    assign eb[2] = job_reg.eb_z;

    assign pair      = step_reg[3:1];
    assign second    = step_reg[0];
    assign rstep     = step_reg - 4'd1;
    assign det       = DET_W'(num_reg[0]);
    assign det_zero  = (det == '0);
    assign out_free  = !out_valid_reg || m_tready;
    assign last_step = (step_reg == 4'd14);
    assign job_ready = (state_reg == ST_IDLE) && !done_reg;

    // Operand selection: T = dv2*ea - dv1*eb, B = du1*eb - du2*ea.
    always_comb
    begin
        mul_a = job_reg.du1;
        mul_b = EDGE_W'(job_reg.dv2);
        kidx  = 2'd0;
        case (pair)
            3'd0:
            begin
                mul_a = second ? job_reg.dv1 : job_reg.du1;
                mul_b = second ? EDGE_W'(job_reg.du2) : EDGE_W'(job_reg.dv2);
            end
            3'd1, 3'd2, 3'd3:
            begin
                kidx  = 2'(pair - 3'd1);
                mul_a = second ? job_reg.dv1 : job_reg.dv2;
                mul_b = second ? eb[kidx] : ea[kidx];
            end
            3'd4, 3'd5, 3'd6:
            begin
                kidx  = 2'(pair - 3'd4);
                mul_a = second ? job_reg.du2 : job_reg.du1;
                mul_b = second ? ea[kidx] : eb[kidx];
            end
            default:
            begin
                mul_a = job_reg.du1;
                mul_b = EDGE_W'(job_reg.dv2);
            end
        endcase
    end

    assign cur_num = num_reg[3'(comp_reg + 3'd1)];
    assign an      = cur_num[NUM_W-1] ? NUM_W'(-cur_num) : NUM_W'(cur_num);
    assign shifted = {rem_reg[REM_W-2:0], div_reg[DIVD_W-1]};
    assign ge      = (shifted >= {1'b0, ad_reg});

    // Saturate the rounded magnitude into Q16.16 and apply the sign.
    always_comb
    begin
        sat_clip = 1'b0;
        if (!neg_reg)
        begin
            if (div_reg > DIVD_W'(32'h7FFF_FFFF))
            begin
                sat_clip = 1'b1;
                sat_val  = 32'h7FFF_FFFF;
            end
            else
            begin
                sat_val = div_reg[OUT_W-1:0];
            end
        end
        else
        begin
            if (div_reg > DIVD_W'(32'h8000_0000))
            begin
                sat_clip = 1'b1;
                sat_val  = 32'h8000_0000;
            end
            else
            begin
                sat_val = -div_reg[OUT_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid && job_ready) state_next = ST_MUL;
            ST_MUL:  if (last_step) state_next = det_zero ? ST_IDLE : ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 6'(DIVD_W - 1)) state_next = ST_FIN;
            ST_FIN:  state_next = (comp_reg == 3'd5) ? ST_IDLE : ST_LOAD;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            comp_reg      <= '0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && job_valid && job_ready)
            begin
                step_reg <= '0;
                comp_reg <= '0;
            end
            if (state_reg == ST_MUL)
            begin
                step_reg <= step_reg + 4'd1;
                if (last_step && det_zero)
                begin
                    done_reg <= 1'b1;
                end
            end
            if (state_reg == ST_LOAD)
            begin
                cnt_reg <= '0;
            end
            if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
            if (state_reg == ST_FIN)
            begin
                comp_reg <= comp_reg + 3'd1;
                if (comp_reg == 3'd5)
                begin
                    done_reg <= 1'b1;
                end
            end
            if (done_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
                done_reg      <= 1'b0;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid && job_ready)
        begin
            job_reg   <= job;
            clip_reg  <= 1'b0;
            degen_reg <= 1'b0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= mul_a * mul_b;
            if (step_reg != 4'd0)
            begin
                if (!rstep[0])
                begin
                    hold_reg <= prod_reg;
                end
                else
                begin
                    num_reg[rstep[3:1]] <= NUM_W'(hold_reg) - NUM_W'(prod_reg);
                end
            end
            if (last_step && det_zero)
            begin
                degen_reg <= 1'b1;
                for (int i = 0; i < 6; i++)
                begin
                    res_reg[i] <= '0;
                end
            end
        end
        if (state_reg == ST_LOAD)
        begin
            ad_reg  <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
            neg_reg <= cur_num[NUM_W-1] ^ det[DET_W-1];
            div_reg <= {1'b0, an, 16'b0}
                       + DIVD_W'((det[DET_W-1] ? DET_W'(-det) : DET_W'(det)) >> 1);
            rem_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= ge ? shifted - {1'b0, ad_reg} : shifted;
            div_reg <= {div_reg[DIVD_W-2:0], ge};
        end
        if (state_reg == ST_FIN)
        begin
            res_reg[comp_reg] <= sat_val;
            clip_reg          <= clip_reg | sat_clip;
        end
        if (done_reg && out_free)
        begin
            out_data_reg <= {res_reg[5], res_reg[4], res_reg[3],
                             res_reg[2], res_reg[1], res_reg[0]};
            out_user_reg <= {clip_reg, degen_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("degenerate result carries data or a clip flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (step_reg <= 4'd14))
        else $error("product sequencer ran past the last step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (comp_reg <= 3'd5))
        else $error("component index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("solver restarted with a result pending");

endmodule

// ----- rtl/core/triangle_tangent_from_uv_top.sv -----
`timescale 1ns / 1ps
// Top level of the face tangent block: vertex front end, job queue, solver.
// Depends on trd_pkg, trd_front, trd_fifo and trd_back.
//
// Usage. Vertices arrive on the slave stream, one beat per vertex, three
// beats per triangle in corner order. Each beat carries a Q8.16 position and
// a Q2.16 texture coordinate. The first two beats of a triangle are only
// held; the third beat produces exactly one beat on the master stream with
// the Q16.16 face tangent and bitangent. The tuser flags mark a zero UV
// determinant (degenerate, vectors zero) and any saturated component.
//
// Timing. The front end takes one vertex per cycle, but holds a third corner
// while the queue is full. A finished triangle is queued for the solver,
// which uses one shared multiplier for the determinant and six numerators
// and then, for each of the six components, a load state, 62 radix-2
// divider steps and a finish state. The divider sets the sustained rate;
// the solver takes no new triangle until its result has moved to the
// output register. A degenerate triangle skips the divider.
//
// Reset clears the corner counter, the queue and all valid flags; the next
// vertex after reset is corner 0. When the receiver stalls, the output beat
// holds; the solver finishes its next triangle and waits, the queue fills,
// and only then does the slave side stop accepting third corners.
module triangle_tangent_from_uv_top
    import trd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // tangent x,y,z, bitangent x,y,z
    output logic [1:0]            m_tuser   // degenerate, clipped
);

    trd_job_t fe_job, q_job;
    logic     fe_valid, fe_ready, q_valid, q_ready;

    trd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (fe_valid),
        .job_ready (fe_ready),
        .job       (fe_job)
    );

    trd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_job   (fe_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_job   (q_job)
    );

    trd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for triangle_tangent_from_uv_top: streams triangle corners, predicts each
// face tangent and bitangent in exact fixed point, and checks every output beat.
// Depends on trd_pkg and the RTL of the block only.
module testbench;
    import trd_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [TEX_W-1:0] tu;
        logic signed [TEX_W-1:0] tv;
    } corner_t;

    typedef struct {
        logic [OUT_W-1:0] comp [6];
        logic             degenerate;
        logic             clipped;
    } face_t;

    localparam int DRAIN_CYCLES = 1000;
    localparam int STALL_LIMIT  = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    // Predictor state: corner index and the two held corners.
    int      corner_idx;
    corner_t held_corner [2];
    face_t   expected_faces [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 1'b0;
    bit  offering = 1'b0;
    bit  failed = 1'b0;
    bit  done = 1'b0;
    int  quiet_cycles = 0;

    triangle_tangent_from_uv_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // Rounded Q16.16 quotient with saturation; magnitude rounded half away from zero.
    function automatic logic [OUT_W-1:0] q16_quotient(input longint num, input longint den,
                                                      inout logic clip);
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] q;
        bit          neg;
        an  = (num < 0) ? 64'(-num) : 64'(num);
        ad  = (den < 0) ? 64'(-den) : 64'(den);
        q   = ((an << 16) + (ad >> 1)) / ad;
        neg = (num < 0) != (den < 0);
        if (!neg && q > 64'h7FFF_FFFF)
        begin
            clip = 1'b1;
            q = 64'h7FFF_FFFF;
        end
        else if (neg && q > 64'h8000_0000)
        begin
            clip = 1'b1;
            q = 64'h8000_0000;
        end
        if (neg)
            q = -q;
        return q[OUT_W-1:0];
    endfunction

    // Advances the predictor by one corner and queues a face on every third.
    task automatic predict_corner(input corner_t c);
        longint ea [3];
        longint eb [3];
        longint p0 [3];
        longint p1 [3];
        longint p2 [3];
        longint du1, dv1, du2, dv2, det;
        face_t  f;
        if (corner_idx < 2)
        begin
            held_corner[corner_idx] = c;
            corner_idx++;
            return;
        end
        corner_idx = 0;
        p0 = '{held_corner[0].px, held_corner[0].py, held_corner[0].pz};
        p1 = '{held_corner[1].px, held_corner[1].py, held_corner[1].pz};
        p2 = '{c.px, c.py, c.pz};
        for (int k = 0; k < 3; k++)
        begin
            ea[k] = p1[k] - p0[k];
            eb[k] = p2[k] - p0[k];
        end
        du1 = longint'(held_corner[1].tu) - held_corner[0].tu;
        dv1 = longint'(held_corner[1].tv) - held_corner[0].tv;
        du2 = longint'(c.tu) - held_corner[0].tu;
        dv2 = longint'(c.tv) - held_corner[0].tv;
        det = du1 * dv2 - dv1 * du2;
        f.clipped = 1'b0;
        f.degenerate = (det == 0);
        for (int k = 0; k < 3; k++)
        begin
            if (det == 0)
            begin
                f.comp[k] = '0;
                f.comp[3+k] = '0;
            end
            else
            begin
                f.comp[k]   = q16_quotient(dv2 * ea[k] - dv1 * eb[k], det, f.clipped);
                f.comp[3+k] = q16_quotient(du1 * eb[k] - du2 * ea[k], det, f.clipped);
            end
        end
        expected_faces.insert(expected_faces.size(), f);
    endtask

    // Drops the input valid after the last beat of a burst.
    task automatic end_burst();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Sends one corner beat, idling first at the current rate, and predicts it.
    // Valid stays high on return so that the next beat can follow at once.
    task automatic send_corner(input corner_t c);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            end_burst();
            @(negedge clk);
        end
        s_tdata  <= {{(IN_DATA_W - $bits(corner_t)){1'b0}}, c.tv, c.tu, c.pz, c.py, c.px};
        s_tvalid <= 1'b1;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_corner(c);
        @(negedge clk);
    endtask

    function automatic corner_t rand_corner(input bit narrow);
        corner_t c;
        c.px = POS_W'($urandom);
        c.py = POS_W'($urandom);
        c.pz = POS_W'($urandom);
        c.tu = TEX_W'($urandom);
        c.tv = TEX_W'($urandom);
        if (narrow)
        begin
            // Small, mesh-like values keep most components out of saturation.
            c.px = $signed(c.px) >>> $urandom_range(20, 4);
            c.py = $signed(c.py) >>> $urandom_range(20, 4);
            c.pz = $signed(c.pz) >>> $urandom_range(20, 4);
            c.tu = $signed(c.tu) >>> $urandom_range(14, 1);
            c.tv = $signed(c.tv) >>> $urandom_range(14, 1);
        end
        return c;
    endfunction

    task automatic wait_drained();
        while (expected_faces.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: stalls at random, or fully while a long hold-off is in force.
    always @(negedge clk)
    begin
        if (recv_hold)
            m_tready <= 1'b0;
        else
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    // Checker: each output beat is compared with the oldest predicted face.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_faces.size() == 0)
            begin
                $error("unexpected output beat %h", m_tdata);
                failed = 1'b1;
            end
            else
            begin
                face_t f;
                f = expected_faces.pop_front();
                for (int k = 0; k < 6; k++)
                begin
                    if (m_tdata[k*OUT_W +: OUT_W] !== f.comp[k])
                    begin
                        $error("%s%s: expected %h actual %h",
                               k < 3 ? "tangent_" : "bitangent_",
                               (k % 3 == 0) ? "x" : (k % 3 == 1) ? "y" : "z",
                               f.comp[k], m_tdata[k*OUT_W +: OUT_W]);
                        failed = 1'b1;
                    end
                end
                if (m_tuser[0] !== f.degenerate)
                begin
                    $error("degenerate: expected %b actual %b", f.degenerate, m_tuser[0]);
                    failed = 1'b1;
                end
                if (m_tuser[1] !== f.clipped)
                begin
                    $error("clipped: expected %b actual %b", f.clipped, m_tuser[1]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either side, outside a hold-off.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || recv_hold)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT && !done)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic corner_t mk(input int x, input int y, input int z,
                                   input int u, input int v);
        corner_t c;
        c.px = POS_W'(x);
        c.py = POS_W'(y);
        c.pz = POS_W'(z);
        c.tu = TEX_W'(u);
        c.tv = TEX_W'(v);
        return c;
    endfunction

    // Directed faces: unit triangle, degenerate UVs, saturation, field extremes, rounding.
    task automatic test_directed();
        localparam int PMAX = 8388607;
        localparam int PMIN = -8388608;
        localparam int TMAX = 131071;
        localparam int TMIN = -131072;
        send_corner(mk(0, 0, 0, 0, 0));
        send_corner(mk(65536, 0, 0, 65536, 0));
        send_corner(mk(0, 65536, 0, 0, 65536));
        // Collinear UVs give a zero determinant.
        send_corner(mk(100, 200, 300, 1000, 1000));
        send_corner(mk(5, 6, 7, 2000, 2000));
        send_corner(mk(-9, 8, -7, 3000, 3000));
        // Tiny UV area against full-range edges saturates every component but bitangent y, which is zero.
        send_corner(mk(PMIN, PMIN, PMIN, 0, 0));
        send_corner(mk(PMAX, PMAX, PMAX, 1, 0));
        send_corner(mk(PMAX, PMIN, PMAX, 0, 1));
        // Extreme texture coordinates on both sides.
        send_corner(mk(PMAX, PMIN, 0, TMIN, TMIN));
        send_corner(mk(PMIN, PMAX, -1, TMAX, TMIN));
        send_corner(mk(-1, 0, PMAX, TMIN, TMAX));
        send_corner(mk(0, 0, 0, TMAX, TMAX));
        send_corner(mk(1, -1, 1, TMIN, TMAX));
        send_corner(mk(-1, 1, -1, TMAX, TMIN));
        // A quotient that must be rounded: one third of a unit tangent.
        send_corner(mk(0, 0, 0, 0, 0));
        send_corner(mk(1, 0, 0, 3, 0));
        send_corner(mk(0, 1, 0, 0, 3));
        end_burst();
        wait_drained();
    endtask

    task automatic test_random_phase(input int faces, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < faces; n++)
            for (int k = 0; k < 3; k++)
                send_corner(rand_corner($urandom_range(3, 0) != 0));
        end_burst();
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering, then the sender
    // pauses until every face has come back.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b1;
        fork
            begin
                repeat (3000)
                    @(negedge clk);
                recv_hold = 1'b0;
            end
            begin
                for (int k = 0; k < 24; k++)
                    send_corner(rand_corner(1'b1));
                end_burst();
            end
        join
        wait_drained();
    endtask

    initial
    begin
        corner_idx = 0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phase(140, 0, 0);
        test_random_phase(140, 66, 0);
        test_random_phase(140, 0, 66);
        test_random_phase(140, 9, 9);
        test_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        done = 1'b1;
        if (!failed && expected_faces.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
